### sv/mfh_pkg.sv
`default_nettype none

package mfh_pkg;

    localparam int HeaderWidth = 32;
    localparam int FrameWidth  = 11;
    localparam int ChanWidth   = 2;
    localparam int RateWidth   = 16;
    localparam int ErrWidth    = 3;
    localparam int RateIdxW    = 4;
    localparam int BrIdxW      = 4;
    localparam int RateCount   = 9;
    localparam int BrCount     = 16;

    typedef enum logic [ErrWidth-1:0] {
        ERR_OK       = 3'd0,
        ERR_SYNC     = 3'd1,
        ERR_LAYER    = 3'd2,
        ERR_RESRATE  = 3'd3,
        ERR_FREEFMT  = 3'd4,
        ERR_BITRATE  = 3'd5
    } err_code_t;

    localparam logic [HeaderWidth-1:0] SyncMask    = 32'hFFE0_0000;
    localparam logic [HeaderWidth-1:0] ResPatMask  = 32'h0000_FC00;

    localparam logic [1:0] LayerThree = 2'b01;
    localparam logic [1:0] CodeResv   = 2'd3;
    localparam logic [1:0] ModeMono   = 2'd3;
    localparam logic [BrIdxW-1:0] BrFree = 4'd0;
    localparam logic [BrIdxW-1:0] BrBad  = 4'd15;
    localparam logic [ChanWidth-1:0] ChanMono   = 2'd1;
    localparam logic [ChanWidth-1:0] ChanStereo = 2'd2;

    // rows 0..2 MPEG-1, 3..5 MPEG-2, 6..8 MPEG-2.5
    localparam logic [RateWidth-1:0] RATE_HZ [RateCount] = '{
        16'd44100, 16'd48000, 16'd32000,
        16'd22050, 16'd24000, 16'd16000,
        16'd11025, 16'd12000, 16'd8000
    };

    // floor(144000 * kbps / (rate << lsf)), padding excluded
    localparam logic [FrameWidth-1:0] FRAME_LEN [RateCount][BrCount] = '{
        '{11'd0, 11'd104, 11'd130, 11'd156, 11'd182, 11'd208, 11'd261, 11'd313,
          11'd365, 11'd417, 11'd522, 11'd626, 11'd731, 11'd835, 11'd1044, 11'd0},
        '{11'd0, 11'd96, 11'd120, 11'd144, 11'd168, 11'd192, 11'd240, 11'd288,
          11'd336, 11'd384, 11'd480, 11'd576, 11'd672, 11'd768, 11'd960, 11'd0},
        '{11'd0, 11'd144, 11'd180, 11'd216, 11'd252, 11'd288, 11'd360, 11'd432,
          11'd504, 11'd576, 11'd720, 11'd864, 11'd1008, 11'd1152, 11'd1440, 11'd0},
        '{11'd0, 11'd26, 11'd52, 11'd78, 11'd104, 11'd130, 11'd156, 11'd182,
          11'd208, 11'd261, 11'd313, 11'd365, 11'd417, 11'd470, 11'd522, 11'd0},
        '{11'd0, 11'd24, 11'd48, 11'd72, 11'd96, 11'd120, 11'd144, 11'd168,
          11'd192, 11'd240, 11'd288, 11'd336, 11'd384, 11'd432, 11'd480, 11'd0},
        '{11'd0, 11'd36, 11'd72, 11'd108, 11'd144, 11'd180, 11'd216, 11'd252,
          11'd288, 11'd360, 11'd432, 11'd504, 11'd576, 11'd648, 11'd720, 11'd0},
        '{11'd0, 11'd52, 11'd104, 11'd156, 11'd208, 11'd261, 11'd313, 11'd365,
          11'd417, 11'd522, 11'd626, 11'd731, 11'd835, 11'd940, 11'd1044, 11'd0},
        '{11'd0, 11'd48, 11'd96, 11'd144, 11'd192, 11'd240, 11'd288, 11'd336,
          11'd384, 11'd480, 11'd576, 11'd672, 11'd768, 11'd864, 11'd960, 11'd0},
        '{11'd0, 11'd72, 11'd144, 11'd216, 11'd288, 11'd360, 11'd432, 11'd504,
          11'd576, 11'd720, 11'd864, 11'd1008, 11'd1152, 11'd1296, 11'd1440, 11'd0}
    };

endpackage

`default_nettype wire

### sv/mfh_if.sv
`default_nettype none

interface mfh_hdr_if;
    import mfh_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [HeaderWidth-1:0] header_word;

    modport source (output valid, output header_word, input ready);
    modport sink   (input valid, input header_word, output ready);
endinterface

interface mfh_res_if;
    import mfh_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [FrameWidth-1:0] frame_bytes;
    logic [ChanWidth-1:0]  channel_count;
    logic [RateWidth-1:0]  sample_rate_hz;
    logic [ErrWidth-1:0]   error_code;

    modport source (output valid, output frame_bytes, output channel_count,
                    output sample_rate_hz, output error_code, input ready);
    modport sink   (input valid, input frame_bytes, input channel_count,
                    input sample_rate_hz, input error_code, output ready);
endinterface

`default_nettype wire

### sv/mp3_frame_header_parse.sv
// Channel  Dir  Payload                                                Width
// hdr      in   header_word                                            32
// res      out  frame_bytes, channel_count, sample_rate_hz, error_code 11/2/16/3
//
// Three register stages: decode and checks, table lookup, padding add.
// One transaction per cycle sustained while res is ready.
// rst_n clears the stage valid bits only; payload registers are not reset.
// A stall on res backs up through the stages; a stage only loads when the
// one after it is empty or moving, so nothing is dropped or repeated.
`default_nettype none

module mp3_frame_header_parse (
    input  wire logic clk,
    input  wire logic rst_n,
    mfh_hdr_if.sink   hdr,
    mfh_res_if.source res
);
    import mfh_pkg::*;

    typedef struct packed {
        err_code_t             err;
        logic [RateIdxW-1:0]   rate_idx;
        logic [BrIdxW-1:0]     br_idx;
        logic                  pad;
        logic [ChanWidth-1:0]  chans;
    } dec_t;

    typedef struct packed {
        err_code_t             err;
        logic [FrameWidth-1:0] frame;
        logic [RateWidth-1:0]  rate;
        logic                  pad;
        logic [ChanWidth-1:0]  chans;
    } look_t;

    logic                  v1_reg, v2_reg, v3_reg;
    logic                  v1_next, v2_next, v3_next;
    logic                  en1, en2, en3;
    dec_t                  s1_reg, s1_next;
    look_t                 s2_reg, s2_next;
    logic [FrameWidth-1:0] bytes_reg, bytes_next;
    logic [ChanWidth-1:0]  chans_reg;
    logic [RateWidth-1:0]  rate_reg;
    err_code_t             err_reg;

    assign en3 = !v3_reg || res.ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign hdr.ready = en1;

    assign v1_next = en1 ? hdr.valid : v1_reg;
    assign v2_next = en2 ? v1_reg    : v2_reg;
    assign v3_next = en3 ? v2_reg    : v3_reg;

    // stage 1: checks in priority order, table indices
    always_comb
    begin
        logic [HeaderWidth-1:0] h;
        logic [1:0]             code;
        logic [BrIdxW-1:0]      br;
        logic                   lsf;
        h    = hdr.header_word;
        code = h[11:10];
        br   = h[15:12];
        lsf  = !(h[20] && h[19]);
        s1_next = '0;
        if ((h & SyncMask) != SyncMask || (h & ResPatMask) == ResPatMask)
        begin
            s1_next.err = ERR_SYNC;
        end
        else if (h[18:17] != LayerThree)
        begin
            s1_next.err = ERR_LAYER;
        end
        else if (code == CodeResv)
        begin
            s1_next.err = ERR_RESRATE;
        end
        else if (br == BrFree)
        begin
            s1_next.err = ERR_FREEFMT;
        end
        else if (br == BrBad)
        begin
            s1_next.err = ERR_BITRATE;
        end
        else
        begin
            s1_next.err    = ERR_OK;
            s1_next.br_idx = br;
            if (!h[20])
                s1_next.rate_idx = RateIdxW'(6) + RateIdxW'(code);
            else if (lsf)
                s1_next.rate_idx = RateIdxW'(3) + RateIdxW'(code);
            else
                s1_next.rate_idx = RateIdxW'(code);
            s1_next.pad   = h[9];
            s1_next.chans = (h[7:6] == ModeMono) ? ChanMono : ChanStereo;
        end
    end

    // stage 2: lookups, zeroed on error
    always_comb
    begin
        s2_next       = '0;
        s2_next.err   = s1_reg.err;
        s2_next.pad   = s1_reg.pad;
        s2_next.chans = s1_reg.chans;
        if (s1_reg.err == ERR_OK)
        begin
            s2_next.frame = FRAME_LEN[s1_reg.rate_idx][s1_reg.br_idx];
            s2_next.rate  = RATE_HZ[s1_reg.rate_idx];
        end
    end

    // stage 3: padding slot
    assign bytes_next = s2_reg.frame + FrameWidth'(s2_reg.pad);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
            s1_reg <= s1_next;
        if (en2)
            s2_reg <= s2_next;
        if (en3)
        begin
            bytes_reg <= bytes_next;
            chans_reg <= s2_reg.chans;
            rate_reg  <= s2_reg.rate;
            err_reg   <= s2_reg.err;
        end
    end

    assign res.valid          = v3_reg;
    assign res.frame_bytes    = bytes_reg;
    assign res.channel_count  = chans_reg;
    assign res.sample_rate_hz = rate_reg;
    assign res.error_code     = err_reg;

endmodule

`default_nettype wire

### sv/mfh_chk.sv
`default_nettype none

module mfh_chk (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            hdr_valid,
    input wire logic                            hdr_ready,
    input wire logic                            res_valid,
    input wire logic                            res_ready,
    input wire logic [mfh_pkg::FrameWidth-1:0]  frame_bytes,
    input wire logic [mfh_pkg::ChanWidth-1:0]   channel_count,
    input wire logic [mfh_pkg::RateWidth-1:0]   sample_rate_hz,
    input wire logic [mfh_pkg::ErrWidth-1:0]    error_code
);
    import mfh_pkg::*;

    logic hdr_acc;
    assign hdr_acc = hdr_valid && hdr_ready;

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(frame_bytes)
            && $stable(channel_count) && $stable(sample_rate_hz)
            && $stable(error_code))
        else $error("result changed while stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && error_code != ERR_OK |->
            frame_bytes == '0 && channel_count == '0 && sample_rate_hz == '0)
        else $error("error transaction carries non-zero fields");

    a_ok_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && error_code == ERR_OK |->
            frame_bytes != '0 && channel_count != '0 && sample_rate_hz != '0)
        else $error("good header decoded to an empty field");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_acc ##1 res_ready ##1 res_ready |=> res_valid)
        else $error("accepted header did not appear after three cycles");

endmodule

bind mp3_frame_header_parse mfh_chk u_mfh_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .hdr_valid      (hdr.valid),
    .hdr_ready      (hdr.ready),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .frame_bytes    (res.frame_bytes),
    .channel_count  (res.channel_count),
    .sample_rate_hz (res.sample_rate_hz),
    .error_code     (res.error_code)
);

`default_nettype wire
